// File: hdl/seven_segment_display_scanner_unit_macros.svh
// Assertion macros shared by the display scanner modules.
`ifndef SEVEN_SEGMENT_DISPLAY_SCANNER_UNIT_MACROS_SVH
`define SEVEN_SEGMENT_DISPLAY_SCANNER_UNIT_MACROS_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define SSDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define SSDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ssds_pkg.sv
// Types, command codes and the character font for the display scanner.
`timescale 1ns / 1ps

package ssds_pkg;

  // Command codes of an input item.
  localparam logic [2:0] CMD_CHAR   = 3'd0;
  localparam logic [2:0] CMD_NUMBER = 3'd1;
  localparam logic [2:0] CMD_RAW    = 3'd2;
  localparam logic [2:0] CMD_MASK   = 3'd3;
  localparam logic [2:0] CMD_BLINK  = 3'd4;
  localparam logic [2:0] CMD_SCAN   = 3'd5;

  // Configuration register map.
  localparam int unsigned CFG_AW           = 2;
  localparam logic [CFG_AW-1:0] ADDR_BLINK_PERIOD = 2'd0;
  localparam logic [7:0]  BLINK_PERIOD_RST = 8'd20;

  // Character classes and font slots.
  localparam logic [7:0] ASCII_UPPER_A  = 8'd65;
  localparam logic [7:0] ASCII_UPPER_END = 8'd91;
  localparam logic [7:0] ASCII_LOWER_A  = 8'd97;
  localparam logic [7:0] ASCII_LOWER_END = 8'd123;
  localparam logic [7:0] ASCII_ZERO     = 8'd48;
  localparam logic [7:0] ASCII_DIGIT_END = 8'd58;
  localparam logic [7:0] ASCII_QUESTION = 8'd63;
  localparam logic [7:0] UPPER_OFFSET   = 8'd55;
  localparam logic [7:0] LOWER_OFFSET   = 8'd87;
  localparam logic [5:0] FONT_QUESTION  = 6'd36;
  localparam logic [5:0] FONT_BLANK     = 6'd37;
  localparam logic [7:0] SEG_BLANK      = 8'h00;

  localparam logic [7:0] FONT [38] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67,
    8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h11, 8'h0E,
    8'h75, 8'h38, 8'h55, 8'h54, 8'h5C, 8'h73, 8'h67, 8'h50, 8'h2D, 8'h78,
    8'h1C, 8'h2A, 8'h6A, 8'h49, 8'h6E, 8'h1B, 8'h53, 8'h00
  };

  typedef struct packed {
    logic [2:0] cmd;
    logic [2:0] position;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] row_drive;
    logic [7:0] column_drive;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       exec;
    logic       num_wr;
    logic [1:0] num_sel;
  } ssds_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_number;
  } ssds_sts_t;

  // Segment pattern of a decimal digit.
  function automatic logic [7:0] digit_glyph(input logic [3:0] d);
    return FONT[6'(d)];
  endfunction

  // Segment pattern of an ASCII code; unknown codes are blank.
  function automatic logic [7:0] glyph_of(input logic [7:0] c);
    logic [5:0] k;
    if (c >= ASCII_UPPER_A && c < ASCII_UPPER_END) begin
      k = 6'(c - UPPER_OFFSET);
    end else if (c >= ASCII_LOWER_A && c < ASCII_LOWER_END) begin
      k = 6'(c - LOWER_OFFSET);
    end else if (c >= ASCII_ZERO && c < ASCII_DIGIT_END) begin
      k = 6'(c - ASCII_ZERO);
    end else if (c == ASCII_QUESTION) begin
      k = FONT_QUESTION;
    end else begin
      k = FONT_BLANK;
    end
    return FONT[k];
  endfunction

endpackage

// File: hdl/ssds_ctrl.sv
// Command sequencer of the display scanner.
`timescale 1ns / 1ps
`include "seven_segment_display_scanner_unit_macros.svh"

module ssds_ctrl
  import ssds_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  ssds_sts_t sts,
  output ssds_ctl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_NUM  = 3'b100
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] num_cnt_r, num_cnt_nxt;

  assign busy = (state_r != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt   = state_r;
    num_cnt_nxt = num_cnt_r;
    ctl         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        if (sts.is_number) begin
          num_cnt_nxt = 2'd0;
          state_nxt   = S_NUM;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_NUM: begin
        ctl.num_wr  = 1'b1;
        ctl.num_sel = num_cnt_r;
        num_cnt_nxt = num_cnt_r + 2'd1;
        if (num_cnt_r == 2'd3) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      num_cnt_r <= 2'd0;
    end else begin
      state_r   <= state_nxt;
      num_cnt_r <= num_cnt_nxt;
    end
  end

  `SSDS_ASSERT_NEXT(a_accept_exec, start && !busy, state_r == S_EXEC, "accepted item not executed")
  `SSDS_ASSERT_NEXT(a_plain_done, state_r == S_EXEC && !sts.is_number, !busy, "single step overran")
  `SSDS_ASSERT_NEXT(a_num_done, state_r == S_NUM && num_cnt_r == 2'd3, !busy, "number write overran")

endmodule

// File: hdl/ssds_datapath.sv
// Segment buffer, blink state, scan index and result register.
`timescale 1ns / 1ps
`include "seven_segment_display_scanner_unit_macros.svh"

module ssds_datapath
  import ssds_pkg::*;
#(
  parameter int DIGITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_item,
  input  ssds_ctl_t  ctl,
  input  logic [7:0] blink_period,
  output ssds_sts_t  sts,
  output logic       out_valid,
  output out_item_t  out_item
);

  localparam int IW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  in_item_t         item_r;
  logic [7:0]       seg_r   [DIGITS];
  logic [7:0]       mask_r  [DIGITS];
  logic [7:0]       numg_r  [4];
  logic             phase_r, phase_nxt;
  logic [7:0]       count_r, count_nxt;
  logic [IW-1:0]    scan_r, scan_nxt;
  logic             out_valid_r;
  out_item_t        out_item_r;

  logic             seg_we, mask_we;
  logic [3:0]       wr_pos;
  logic [7:0]       seg_wdata;
  logic             pos_ok;
  logic [1:0]       hund;
  logic [6:0]       rem;
  logic [14:0]      tens_prod;
  logic [3:0]       tens, units;
  logic [7:0]       hide;
  logic             do_scan;

  assign sts.is_number = (item_r.cmd == CMD_NUMBER);
  assign out_valid     = out_valid_r;
  assign out_item      = out_item_r;
  assign do_scan       = ctl.exec && (item_r.cmd == CMD_SCAN);

  // Decimal split: compare for hundreds, reciprocal multiply for tens.
  always_comb begin
    if (item_r.value >= 8'd200) begin
      hund = 2'd2;
      rem  = 7'(item_r.value - 8'd200);
    end else if (item_r.value >= 8'd100) begin
      hund = 2'd1;
      rem  = 7'(item_r.value - 8'd100);
    end else begin
      hund = 2'd0;
      rem  = 7'(item_r.value);
    end
    tens_prod = 15'(rem) * 15'd205;
    tens      = tens_prod[14:11];
    units     = 4'(rem - 7'({tens, 3'b000} + {2'b00, tens, 1'b0}));
  end

  // Single write port into the segment and mask buffers.
  always_comb begin
    seg_we    = 1'b0;
    mask_we   = 1'b0;
    wr_pos    = {1'b0, item_r.position};
    seg_wdata = item_r.value;
    if (ctl.num_wr) begin
      seg_we    = 1'b1;
      wr_pos    = {1'b0, item_r.position} + {2'b00, ctl.num_sel};
      seg_wdata = numg_r[ctl.num_sel];
    end else if (ctl.exec) begin
      case (item_r.cmd)
        CMD_CHAR: begin
          seg_we    = 1'b1;
          seg_wdata = glyph_of(item_r.value);
        end
        CMD_RAW:  seg_we  = 1'b1;
        CMD_MASK: mask_we = 1'b1;
        default: begin
          seg_we = 1'b0;
        end
      endcase
    end
    pos_ok = (wr_pos < 4'(DIGITS));
  end

  // Blink counter and scan index updates.
  always_comb begin
    count_nxt = count_r;
    phase_nxt = phase_r;
    scan_nxt  = scan_r;
    if (ctl.exec && item_r.cmd == CMD_BLINK) begin
      count_nxt = count_r + 8'd1;
      if (count_nxt > blink_period) begin
        count_nxt = 8'd0;
        phase_nxt = ~phase_r;
      end
    end
    if (do_scan) begin
      scan_nxt = (scan_r == IW'(DIGITS - 1)) ? '0 : scan_r + IW'(1);
    end
    hide = phase_r ? mask_r[scan_r] : 8'h00;
  end

  // Latched item, number glyphs and scan output word.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_r <= in_item;
    end
    if (ctl.exec && sts.is_number) begin
      numg_r[0] <= SEG_BLANK;
      numg_r[1] <= (hund == 2'd0) ? SEG_BLANK : digit_glyph({2'b00, hund});
      numg_r[2] <= (tens != 4'd0) ? digit_glyph(tens) :
                   ((hund != 2'd0) ? digit_glyph(4'd0) : SEG_BLANK);
      numg_r[3] <= digit_glyph(units);
    end
    if (do_scan) begin
      out_item_r.row_drive    <= ~(8'd1 << scan_r);
      out_item_r.column_drive <= seg_r[scan_r] & ~hide;
    end
  end

  // Display state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIGITS; i++) begin
        seg_r[i]  <= 8'h00;
        mask_r[i] <= 8'h00;
      end
      phase_r     <= 1'b0;
      count_r     <= 8'd0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (seg_we && pos_ok) begin
        seg_r[wr_pos[IW-1:0]] <= seg_wdata;
      end
      if (mask_we && pos_ok) begin
        mask_r[wr_pos[IW-1:0]] <= item_r.value;
      end
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= do_scan;
    end
  end

  `SSDS_ASSERT_NOW(a_scan_range, 1'b1, scan_r < IW'(DIGITS - 1) || scan_r == IW'(DIGITS - 1), "scan index out of range")
  `SSDS_ASSERT_NEXT(a_strobe_src, do_scan, out_valid_r, "scan tick gave no result")
  `SSDS_ASSERT_NOW(a_row_single, out_valid_r, $countones(out_item_r.row_drive) == 7, "row word not one-cold")

endmodule

// File: hdl/seven_segment_display_scanner_unit.sv
// Top level of the multiplexed seven-segment display scanner.
// busy is high while an item is at work: it is latched and run in the EXEC state,
// and a scan tick's result is registered; a new item waits until the last is done.
// A number write puts one digit per cycle through the single buffer write port.
// Results appear for one cycle on out_valid; the receiver cannot stall.
// Reset (rst_n, synchronous) clears buffers, masks, blink state, scan index
// and returns blink_period to 20.
`timescale 1ns / 1ps

module seven_segment_display_scanner_unit
  import ssds_pkg::*;
#(
  parameter int DIGITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_item,
  output logic              out_valid,
  output out_item_t         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  ssds_ctl_t  ctl;
  ssds_sts_t  sts;
  logic [7:0] blink_period_r;

  assign pready = 1'b1;

  // Configuration register write and read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_period_r <= BLINK_PERIOD_RST;
    end else if (psel && penable && pwrite && paddr == ADDR_BLINK_PERIOD) begin
      blink_period_r <= pwdata[7:0];
    end
  end

  assign prdata = (paddr == ADDR_BLINK_PERIOD) ? {24'd0, blink_period_r} : 32'd0;

  ssds_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  ssds_datapath #(
    .DIGITS (DIGITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_item      (in_item),
    .ctl          (ctl),
    .blink_period (blink_period_r),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_item     (out_item)
  );

endmodule

// File: tb/sv/scan_frame_checker.sv
// Display scanner checker: predicts every scan frame and compares it with the block's output.
`timescale 1ns / 1ps

module scan_frame_checker
  import ssds_pkg::*;
#(
  parameter int DIGITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  in_item_t          in_item,
  input  logic              out_valid,
  input  out_item_t         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int                mismatches,
  output int                pending
);

  localparam int REPORT_LIMIT = 10;

  // Shadow copy of the display state.
  logic [7:0]  seg_buf [DIGITS];
  logic [7:0]  blink_bits [DIGITS];
  logic        blink_on;
  logic [7:0]  tick_count;
  logic [7:0]  blink_period;
  int unsigned scan_pos;

  out_item_t   expected_frames [$];
  int          bad_count;

  initial begin
    mismatches = 0;
    pending    = 0;
    bad_count  = 0;
  end

  // Segment pattern that a character write puts into the buffer.
  function automatic logic [7:0] char_segments(input logic [7:0] c);
    int code;
    code = int'(c);
    if (code >= 65 && code <= 90) begin
      return FONT[code - 55];
    end else if (code >= 97 && code <= 122) begin
      return FONT[code - 87];
    end else if (code >= 48 && code <= 57) begin
      return FONT[code - 48];
    end else if (code == 63) begin
      return FONT[FONT_QUESTION];
    end
    return SEG_BLANK;
  endfunction

  // Writes past the last digit are dropped.
  task automatic store_digit(input int pos, input logic [7:0] seg);
    if (pos < DIGITS) begin
      seg_buf[pos] = seg;
    end
  endtask

  // A number takes four digits: blank, hundreds, tens, units with leading zeros blanked.
  task automatic store_number(input logic [7:0] num, input int first);
    int hundreds;
    int tens;
    int units;
    hundreds = int'(num) / 100;
    tens     = (int'(num) / 10) % 10;
    units    = int'(num) % 10;
    store_digit(first, SEG_BLANK);
    store_digit(first + 1, (hundreds != 0) ? FONT[hundreds] : SEG_BLANK);
    store_digit(first + 2, (hundreds != 0 || tens != 0) ? FONT[tens] : SEG_BLANK);
    store_digit(first + 3, FONT[units]);
  endtask

  // Updates the shadow state for one accepted item and queues its frame, if any.
  task automatic apply_command(input in_item_t it);
    out_item_t frame;
    int        pos;
    pos = int'(it.position);
    case (it.cmd)
      CMD_CHAR: begin
        store_digit(pos, char_segments(it.value));
      end
      CMD_NUMBER: begin
        store_number(it.value, pos);
      end
      CMD_RAW: begin
        store_digit(pos, it.value);
      end
      CMD_MASK: begin
        if (pos < DIGITS) begin
          blink_bits[pos] = it.value;
        end
      end
      CMD_BLINK: begin
        tick_count = tick_count + 8'd1;
        if (tick_count > blink_period) begin
          tick_count = 8'd0;
          blink_on   = ~blink_on;
        end
      end
      CMD_SCAN: begin
        frame.row_drive    = ~(8'd1 << scan_pos);
        frame.column_drive = seg_buf[scan_pos] & ~(blink_on ? blink_bits[scan_pos] : 8'h00);
        expected_frames.push_back(frame);
        scan_pos = (scan_pos + 1) % DIGITS;
      end
      default: begin
      end
    endcase
  endtask

  // Compares one frame from the block with the oldest prediction.
  task automatic check_frame(input out_item_t got);
    out_item_t want;
    if (expected_frames.size() == 0) begin
      bad_count++;
      if (bad_count <= REPORT_LIMIT) begin
        $display("unexpected frame: row %02h col %02h", got.row_drive, got.column_drive);
      end
    end else begin
      want = expected_frames.pop_front();
      if (got.row_drive !== want.row_drive || got.column_drive !== want.column_drive) begin
        bad_count++;
        if (bad_count <= REPORT_LIMIT) begin
          $display("frame mismatch: expected row %02h col %02h, got row %02h col %02h",
                   want.row_drive, want.column_drive, got.row_drive, got.column_drive);
        end
      end
    end
  endtask

  // All channels are sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIGITS; i++) begin
        seg_buf[i]    = 8'h00;
        blink_bits[i] = 8'h00;
      end
      blink_on     = 1'b0;
      tick_count   = 8'd0;
      scan_pos     = 0;
      blink_period = BLINK_PERIOD_RST;
      expected_frames.delete();
    end else begin
      if (out_valid) begin
        check_frame(out_item);
      end
      if (psel && penable && pwrite && pready && paddr == ADDR_BLINK_PERIOD) begin
        blink_period = pwdata[7:0];
      end
      if (start && !busy) begin
        apply_command(in_item);
      end
    end
    mismatches <= bad_count;
    pending    <= expected_frames.size();
  end

endmodule

// File: tb/sv/testbench.sv
// Top of the display scanner testbench: clock, reset, item and register stimulus, verdict.
`timescale 1ns / 1ps

module testbench
  import ssds_pkg::*;
();

  localparam int          DIGITS          = 8;
  localparam logic [2:0]  CMD_UNUSED_LO   = 3'd6;
  localparam logic [2:0]  CMD_UNUSED_HI   = 3'd7;
  localparam int          ITEMS_PER_PHASE = 270;
  localparam int          PHASES          = 6;
  localparam int          SETTLE_CYCLES   = 10;
  localparam int          WATCHDOG_LIMIT  = 3000;

  logic              clk;
  logic              rst_n   = 1'b0;
  logic              start   = 1'b0;
  logic              busy;
  in_item_t          in_item = '0;
  logic              out_valid;
  out_item_t         out_item;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [CFG_AW-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  int                mismatches;
  int                pending_frames;
  int                idle_cycles = 0;

  seven_segment_display_scanner_unit #(
    .DIGITS(DIGITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  scan_frame_checker #(
    .DIGITS(DIGITS)
  ) frame_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .mismatches(mismatches),
    .pending   (pending_frames)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Ends the run when nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_item_t make_item(input logic [2:0] cmd, input int pos, input int val);
    in_item_t it;
    it.cmd      = cmd;
    it.position = 3'(pos);
    it.value    = 8'(val);
    return it;
  endfunction

  // Random item with a mix weighted toward scan and blink ticks.
  function automatic in_item_t random_item();
    int          pick;
    logic [2:0]  cmd;
    logic [7:0]  val;
    pick = $urandom_range(99);
    val  = 8'($urandom_range(255));
    if (pick < 10) begin
      cmd = CMD_CHAR;
      if ($urandom_range(1) == 0) begin
        val = 8'($urandom_range(32, 127));
      end
    end else if (pick < 17) begin
      cmd = CMD_NUMBER;
    end else if (pick < 24) begin
      cmd = CMD_RAW;
    end else if (pick < 32) begin
      cmd = CMD_MASK;
    end else if (pick < 58) begin
      cmd = CMD_BLINK;
    end else if (pick < 96) begin
      cmd = CMD_SCAN;
    end else if (pick < 98) begin
      cmd = CMD_UNUSED_LO;
    end else begin
      cmd = CMD_UNUSED_HI;
    end
    return make_item(cmd, $urandom_range(7), int'(val));
  endfunction

  // Presents one item and returns at the edge that accepts it; start stays high.
  task automatic issue_item(input in_item_t it);
    in_item <= it;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
  endtask

  // Waits until every predicted frame has arrived and the block has gone quiet.
  task automatic drain();
    @(posedge clk);
    while (pending_frames != 0 || busy) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_register(input logic [CFG_AW-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Sends items in bursts of random length separated by random gaps.
  task automatic send_random(input int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      for (int k = 0; k < burst && sent < count; k++) begin
        issue_item(random_item());
        sent++;
      end
      start <= 1'b0;
      if ($urandom_range(29) == 0) begin
        drain();
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  initial begin
    in_item_t directed [$];
    logic [7:0] period;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: font edges, number layouts, dropped digits, masks and unused codes.
    directed.push_back(make_item(CMD_CHAR, 0, 65));
    directed.push_back(make_item(CMD_CHAR, 1, 122));
    directed.push_back(make_item(CMD_CHAR, 2, 48));
    directed.push_back(make_item(CMD_CHAR, 3, 57));
    directed.push_back(make_item(CMD_CHAR, 4, 63));
    directed.push_back(make_item(CMD_CHAR, 5, 32));
    directed.push_back(make_item(CMD_CHAR, 6, 255));
    directed.push_back(make_item(CMD_CHAR, 7, 90));
    directed.push_back(make_item(CMD_NUMBER, 0, 255));
    directed.push_back(make_item(CMD_NUMBER, 4, 7));
    directed.push_back(make_item(CMD_NUMBER, 6, 100));
    directed.push_back(make_item(CMD_NUMBER, 5, 0));
    directed.push_back(make_item(CMD_RAW, 1, 255));
    directed.push_back(make_item(CMD_RAW, 2, 0));
    directed.push_back(make_item(CMD_MASK, 1, 255));
    directed.push_back(make_item(CMD_MASK, 7, 85));
    directed.push_back(make_item(CMD_BLINK, 0, 0));
    directed.push_back(make_item(CMD_UNUSED_LO, 3, 170));
    directed.push_back(make_item(CMD_UNUSED_HI, 4, 85));
    for (int i = 0; i < 6; i++) begin
      directed.push_back(make_item(CMD_SCAN, i, 255 - i));
    end
    foreach (directed[i]) begin
      issue_item(directed[i]);
    end
    start <= 1'b0;
    drain();

    // Random phases, each under its own blink period; the register is written while idle.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       period = 8'd0;
        1:       period = 8'd255;
        2:       period = 8'd1;
        3:       period = 8'd3;
        4:       period = 8'($urandom_range(2, 30));
        default: period = BLINK_PERIOD_RST;
      endcase
      write_register(ADDR_BLINK_PERIOD, {24'($urandom), period});
      @(posedge clk);
      send_random(ITEMS_PER_PHASE);
      drain();
    end

    if (mismatches == 0 && pending_frames == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
